@@ rtl/hufd_pkg.sv @@
// Shared constants, event codes and result type for the Huffman table builder and decoder.
package hufd_pkg;

    localparam int unsigned GLYPH_W        = 8;
    localparam int unsigned NODE_COUNT_DEF = 512;
    localparam int unsigned OUT_DEPTH      = 3;

    localparam logic [GLYPH_W-1:0] CH_X     = 8'h58;
    localparam logic [GLYPH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [GLYPH_W-1:0] CH_SEP   = 8'h7F;
    localparam logic [GLYPH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [GLYPH_W-1:0] CH_ONE   = 8'h31;
    localparam logic [GLYPH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [GLYPH_W-1:0] CH_NL    = 8'h0A;

    typedef enum logic [2:0] {
        EV_SYMBOL   = 3'd0,
        EV_SEP_WARN = 3'd1,
        EV_EMPTY    = 3'd2,
        EV_FORMAT   = 3'd3,
        EV_FULL     = 3'd4,
        EV_NONBIN   = 3'd5,
        EV_NOCHILD  = 3'd6,
        EV_MIDCODE  = 3'd7
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [GLYPH_W-1:0] symbol;
    } t_result;

endpackage

@@ rtl/hufd_if.sv @@
// Valid/ready channel interfaces for the input bytes and the decode results.
interface hufd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hufd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] symbol;

    modport source (output valid, output event_res, output symbol, input ready);
    modport sink   (input valid, input event_res, input symbol, output ready);
endinterface

@@ rtl/hufd_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-old on collision).
module hufd_ram #(
    parameter int unsigned WIDTH = 26,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/hufd_out_fifo.sv @@
// Three-entry result queue that decouples the decoder from the result consumer.
module hufd_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hufd_pkg::t_result i_data,
    input  logic              i_inflight,
    output logic              o_room,
    hufd_out_if.source        o_out
);
    import hufd_pkg::*;

    localparam int unsigned PW = $clog2(OUT_DEPTH);
    localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

    t_result         r_q [OUT_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            pop;
    logic [CW:0]     pending;

    assign pop     = o_out.valid && o_out.ready;
    assign pending = {1'b0, r_cnt} + (CW + 1)'(i_inflight);
    // Leave room for the result of every transfer still in the decoder.
    assign o_room  = pending < (CW + 1)'(OUT_DEPTH);

    assign o_out.valid     = r_cnt != '0;
    assign o_out.event_res = r_q[r_rd].event_res;
    assign o_out.symbol    = r_q[r_rd].symbol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_q[r_wr] <= i_data;
                r_wr      <= (r_wr == PW'(OUT_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(OUT_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(pop);
        end
    end
endmodule

@@ rtl/huffman_table_build_and_decode.sv @@
// Top level: header parser, tree builder and bit walker around the node store RAM.
//
//  channel | dir | handshake     | payload
//  i_in    | in  | valid / ready | data_byte[7:0], last_byte
//  o_out   | out | valid / ready | event_res[2:0], symbol[7:0]
//
// One byte per cycle while the result queue has room; results are taken from registered
// state into the queue. The loop from the node RAM read data through the child select to the
// next read address bounds that rate. Reset is synchronous, with no clearing pass:
// nodes are zeroed as they are allocated and the root lives in a register. Input
// ready drops only while the result queue cannot take the results still in flight.
module huffman_table_build_and_decode #(
    parameter int unsigned NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hufd_in_if.sink   i_in,
    hufd_out_if.source o_out
);
    import hufd_pkg::*;

    localparam int unsigned IW = $clog2(NODE_COUNT);
    localparam int unsigned UW = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [IW-1:0]      left;
        logic [IW-1:0]      right;
    } t_node;

    typedef enum logic [2:0] {
        PH_GLYPH, PH_AFTER_X, PH_COLON, PH_FIRST_BIT, PH_BITS, PH_SKIP, PH_DATA
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [IW-1:0]      r_cursor, n_cursor;
    logic               r_fresh, n_fresh;
    logic               r_leaf_chk, n_leaf_chk;
    logic [UW-1:0]      r_used, n_used;
    logic [GLYPH_W-1:0] r_held, n_held;
    logic               r_halted, n_halted;
    t_node              r_root;
    logic               r_fwd_vld;
    logic [IW-1:0]      r_fwd_addr;
    t_node              r_fwd_data;
    logic               r_s2_fixed, n_s2_fixed;
    t_event             r_s2_ev, n_s2_ev;
    logic               r_s2_last, n_s2_last;

    t_node              ram_rdata;
    t_node              raw, cur, base, linked, wdata;
    logic [IW-1:0]      eff_cursor, waddr, link;
    logic               we, leaf, accept, is_bit, do_build, full, room, push;
    logic [GLYPH_W-1:0] b;
    t_result            res;

    hufd_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_cursor),
        .o_rdata (ram_rdata)
    );

    hufd_out_fifo u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (res),
        .i_inflight (r_s2_fixed || r_leaf_chk),
        .o_room     (room),
        .o_out      (o_out)
    );

    assign i_in.ready = room;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    always_comb begin
        // Current node: root register, fresh node, forwarded write, or RAM.
        if (r_cursor == '0) begin
            raw = r_root;
        end else if (r_fresh) begin
            raw = '0;
        end else if (r_fwd_vld && (r_fwd_addr == r_cursor)) begin
            raw = r_fwd_data;
        end else begin
            raw = ram_rdata;
        end

        // A data step that landed on a leaf sends the cursor back to the root.
        leaf       = r_leaf_chk && (raw.glyph != '0);
        eff_cursor = leaf ? '0 : r_cursor;
        cur        = leaf ? r_root : raw;

        // Result of the previous transfer.
        push = r_s2_fixed || leaf || (r_leaf_chk && r_s2_last);
        if (r_s2_fixed) begin
            res = '{event_res: r_s2_ev, symbol: '0};
        end else if (leaf) begin
            res = '{event_res: EV_SYMBOL, symbol: raw.glyph};
        end else begin
            res = '{event_res: EV_MIDCODE, symbol: '0};
        end

        is_bit = (b == CH_ZERO) || (b == CH_ONE);
        base   = (r_phase == PH_FIRST_BIT) ? r_root : cur;
        link   = b[0] ? base.right : base.left;
        linked = base;
        if (b[0]) begin
            linked.right = r_used[IW-1:0];
        end else begin
            linked.left = r_used[IW-1:0];
        end
        full = r_used >= UW'(NODE_COUNT);

        n_phase    = r_phase;
        n_cursor   = eff_cursor;
        n_fresh    = r_fresh;
        n_leaf_chk = 1'b0;
        n_used     = r_used;
        n_held     = r_held;
        n_halted   = r_halted;
        n_s2_fixed = 1'b0;
        n_s2_ev    = EV_SYMBOL;
        n_s2_last  = 1'b0;
        we         = 1'b0;
        waddr      = eff_cursor;
        wdata      = cur;
        do_build   = 1'b0;

        if (accept && !r_halted) begin
            unique case (r_phase)
                PH_GLYPH: begin
                    if ((r_used == UW'(1)) && (b == '0)) begin
                        n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_EMPTY;
                    end else if (b == CH_X) begin
                        n_phase = PH_AFTER_X;
                    end else begin
                        n_held  = b;
                        n_phase = PH_COLON;
                    end
                end
                PH_AFTER_X: begin
                    if (b == CH_X) begin
                        if (r_used == UW'(1)) begin
                            n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_EMPTY;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        // Lone X is the glyph; this byte must be the colon.
                        n_held = CH_X;
                        if (b != CH_COLON) begin
                            n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_FORMAT;
                        end else begin
                            n_phase = PH_FIRST_BIT;
                        end
                    end
                end
                PH_COLON: begin
                    if (b != CH_COLON) begin
                        n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_FORMAT;
                    end else begin
                        n_phase = PH_FIRST_BIT;
                    end
                end
                PH_FIRST_BIT: begin
                    if (!is_bit) begin
                        n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_FORMAT;
                    end else begin
                        n_phase  = PH_BITS;
                        do_build = 1'b1;
                    end
                end
                PH_BITS: begin
                    if (is_bit) begin
                        do_build = 1'b1;
                    end else begin
                        // End of code: store the glyph, return to the root.
                        we          = 1'b1;
                        wdata.glyph = r_held;
                        n_cursor    = '0;
                        n_fresh     = 1'b0;
                        n_phase     = PH_GLYPH;
                        if (b != CH_SEP) begin
                            n_s2_fixed = 1'b1; n_s2_ev = EV_SEP_WARN;
                        end
                    end
                end
                PH_SKIP, PH_DATA: begin
                    if ((r_phase == PH_SKIP) && ((b == CH_SPACE) || (b == CH_NL))) begin
                        n_phase = PH_SKIP;
                    end else if (!is_bit) begin
                        n_phase  = PH_DATA;
                        n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_NONBIN;
                    end else if (link == '0) begin
                        n_phase  = PH_DATA;
                        n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_NOCHILD;
                    end else begin
                        n_phase    = PH_DATA;
                        n_cursor   = link;
                        n_fresh    = 1'b0;
                        n_leaf_chk = 1'b1;
                    end
                end
                default: begin
                    n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_FORMAT;
                end
            endcase

            if (do_build) begin
                if (link != '0) begin
                    n_cursor = link;
                    n_fresh  = 1'b0;
                end else if (full) begin
                    n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_FULL;
                end else begin
                    // Allocate the next node and hook it under the parent.
                    we       = 1'b1;
                    waddr    = (r_phase == PH_FIRST_BIT) ? '0 : eff_cursor;
                    wdata    = linked;
                    n_used   = r_used + 1'b1;
                    n_cursor = r_used[IW-1:0];
                    n_fresh  = 1'b1;
                end
            end

            if (i_in.last_byte && !n_halted) begin
                if ((n_phase == PH_SKIP) || (n_phase == PH_DATA)) begin
                    n_s2_last = n_leaf_chk;
                end else begin
                    n_halted = 1'b1; n_s2_fixed = 1'b1; n_s2_ev = EV_FORMAT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_GLYPH;
            r_cursor   <= '0;
            r_fresh    <= 1'b0;
            r_leaf_chk <= 1'b0;
            r_used     <= UW'(1);
            r_held     <= '0;
            r_halted   <= 1'b0;
            r_root     <= '0;
            r_fwd_vld  <= 1'b0;
            r_s2_fixed <= 1'b0;
            r_s2_last  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cursor   <= n_cursor;
            r_fresh    <= n_fresh;
            r_leaf_chk <= n_leaf_chk;
            r_used     <= n_used;
            r_held     <= n_held;
            r_halted   <= n_halted;
            r_fwd_vld  <= we;
            r_s2_fixed <= n_s2_fixed;
            r_s2_last  <= n_s2_last;
            if (we && (waddr == '0)) begin
                r_root <= wdata;
            end
        end
        r_fwd_addr <= waddr;
        r_fwd_data <= wdata;
        r_s2_ev    <= n_s2_ev;
    end
endmodule

@@ tb/huffman_table_build_and_decode_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the Huffman table builder and decoder: directed stream, random decode, checker.
module huffman_table_build_and_decode_tb;
    import hufd_pkg::*;

    localparam int unsigned NODES        = NODE_COUNT_DEF;
    localparam int unsigned N_DIR        = 26;
    localparam int unsigned N_DECODE     = 1200;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RES
    } t_check;

    typedef enum logic [2:0] {
        PS_GLYPH,
        PS_AFTER_X,
        PS_COLON,
        PS_FIRST_BIT,
        PS_BITS,
        PS_SKIP,
        PS_DATA
    } t_parse;

    typedef struct packed {
        logic [7:0] b;
        logic       lst;
        t_check     chk;
        t_event     ev;
        logic [7:0] sym;
    } t_row;

    // Three codes: 0 -> 8'hFF, 10 -> 'X' (lone X), 111 -> 8'h01 with a bad separator.
    localparam t_row DIR_ROWS [N_DIR] = '{
        '{8'hFF,    1'b0, CHK_NONE,  EV_SYMBOL,   8'h00},
        '{CH_COLON, 1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ZERO,  1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_SEP,   1'b0, CHK_NONE,  EV_SYMBOL,   8'h00},
        '{CH_X,     1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_COLON, 1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ONE,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ZERO,  1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_SEP,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{8'h01,    1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_COLON, 1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ONE,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ONE,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ONE,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{8'h41,    1'b0, CHK_RES,   EV_SEP_WARN, 8'h00},
        '{CH_X,     1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_X,     1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_SPACE, 1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_NL,    1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ZERO,  1'b0, CHK_RES,   EV_SYMBOL,   8'hFF},
        '{CH_ONE,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ZERO,  1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ONE,   1'b1, CHK_RES,   EV_MIDCODE,  8'h00},
        '{CH_ONE,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ONE,   1'b0, CHK_MODEL, EV_SYMBOL,   8'h00},
        '{CH_ZERO,  1'b1, CHK_RES,   EV_SYMBOL,   8'hFF}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;

    hufd_in_if  byte_if ();
    hufd_out_if res_if ();

    assign res_if.ready = sink_ready;

    huffman_table_build_and_decode i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (res_if)
    );

    // Decoder model state
    logic [7:0]  tr_glyph [NODES];
    int unsigned tr_lft [NODES];
    int unsigned tr_rgt [NODES];
    int unsigned tr_used;
    int unsigned tr_cur;
    t_parse      tr_phase;
    logic [7:0]  tr_held;
    bit          tr_halted;

    t_result     expected_q [$];
    t_result     want_res;
    int unsigned n_errors = 0;
    int unsigned n_sent = 0;
    int unsigned cycle_cnt = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the decoder model by one byte; returns 1 when the byte yields a result.
    function automatic bit predict_byte(input logic [7:0] b, input logic lst,
                                        output t_event ev, output logic [7:0] sym);
        bit          got;
        bit          is_bit;
        int unsigned nxt;
        got = 1'b0;
        ev  = EV_SYMBOL;
        sym = 8'h00;
        if (tr_halted) return 1'b0;
        is_bit = (b == CH_ZERO) || (b == CH_ONE);
        if (tr_phase == PS_SKIP && b != CH_SPACE && b != CH_NL) tr_phase = PS_DATA;
        case (tr_phase)
            PS_GLYPH: begin
                if (tr_used == 1 && b == 8'h00) begin
                    got = 1'b1;
                    ev  = EV_EMPTY;
                end else if (b == CH_X) begin
                    tr_phase = PS_AFTER_X;
                end else begin
                    tr_held  = b;
                    tr_phase = PS_COLON;
                end
            end
            PS_AFTER_X, PS_COLON: begin
                if (tr_phase == PS_AFTER_X && b == CH_X) begin
                    if (tr_used == 1) begin
                        got = 1'b1;
                        ev  = EV_EMPTY;
                    end else begin
                        tr_phase = PS_SKIP;
                    end
                end else begin
                    // a lone X is the glyph itself
                    if (tr_phase == PS_AFTER_X) tr_held = CH_X;
                    if (b != CH_COLON) begin
                        got = 1'b1;
                        ev  = EV_FORMAT;
                    end else begin
                        tr_phase = PS_FIRST_BIT;
                    end
                end
            end
            PS_FIRST_BIT, PS_BITS: begin
                if (is_bit) begin
                    if (tr_phase == PS_FIRST_BIT) tr_cur = 0;
                    tr_phase = PS_BITS;
                    nxt = (b == CH_ZERO) ? tr_lft[tr_cur] : tr_rgt[tr_cur];
                    if (nxt == 0) begin
                        if (tr_used >= NODES) begin
                            got = 1'b1;
                            ev  = EV_FULL;
                        end else begin
                            nxt = tr_used;
                            tr_used++;
                            tr_glyph[nxt] = 8'h00;
                            tr_lft[nxt]   = 0;
                            tr_rgt[nxt]   = 0;
                            if (b == CH_ZERO) tr_lft[tr_cur] = nxt;
                            else tr_rgt[tr_cur] = nxt;
                        end
                    end
                    if (!got) tr_cur = nxt;
                end else if (tr_phase == PS_FIRST_BIT) begin
                    got = 1'b1;
                    ev  = EV_FORMAT;
                end else begin
                    tr_glyph[tr_cur] = tr_held;
                    tr_cur   = 0;
                    tr_phase = PS_GLYPH;
                    if (b != CH_SEP) begin
                        got = 1'b1;
                        ev  = EV_SEP_WARN;
                    end
                end
            end
            PS_SKIP: begin
            end
            default: begin
                nxt = (b == CH_ZERO) ? tr_lft[tr_cur] : tr_rgt[tr_cur];
                if (!is_bit) begin
                    got = 1'b1;
                    ev  = EV_NONBIN;
                end else if (nxt == 0 || nxt >= NODES) begin
                    got = 1'b1;
                    ev  = EV_NOCHILD;
                end else if (tr_glyph[nxt] != 8'h00) begin
                    tr_cur = 0;
                    got    = 1'b1;
                    ev     = EV_SYMBOL;
                    sym    = tr_glyph[nxt];
                end else begin
                    tr_cur = nxt;
                end
            end
        endcase
        // every event but a symbol or a separator warning is fatal
        if (got && ev != EV_SYMBOL && ev != EV_SEP_WARN) tr_halted = 1'b1;
        if (lst && !tr_halted) begin
            if (tr_phase == PS_SKIP || tr_phase == PS_DATA) begin
                if (!got && tr_cur != 0) begin
                    got = 1'b1;
                    ev  = EV_MIDCODE;
                end
            end else begin
                got       = 1'b1;
                ev        = EV_FORMAT;
                sym       = 8'h00;
                tr_halted = 1'b1;
            end
        end
        return got;
    endfunction

    // Pick a bit that follows an existing branch from the cursor.
    function automatic logic [7:0] path_bit();
        if (tr_lft[tr_cur] != 0 && tr_rgt[tr_cur] != 0)
            return $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
        return (tr_lft[tr_cur] != 0) ? CH_ZERO : CH_ONE;
    endfunction

    function automatic logic [7:0] non_bit_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_ZERO || b == CH_ONE);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst, input t_check chk,
                             input t_event ev_typed, input logic [7:0] sym_typed);
        t_event     ev;
        logic [7:0] sym;
        bit         got;
        t_result    r;
        case ((n_sent / 100) % 4)
            0: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            1: begin
                src_idle_pct  = 52;
                snk_stall_pct = 0;
            end
            2: begin
                src_idle_pct  = 0;
                snk_stall_pct = 52;
            end
            default: begin
                src_idle_pct  = 23;
                snk_stall_pct = 23;
            end
        endcase
        got = predict_byte(b, lst, ev, sym);
        if (chk == CHK_NONE) begin
            got = 1'b0;
        end else if (chk == CHK_RES) begin
            got = 1'b1;
            ev  = ev_typed;
            sym = sym_typed;
        end
        if (got) begin
            r.event_res = ev;
            r.symbol    = sym;
            expected_q.push_back(r);
        end
        if ($urandom_range(0, 99) < src_idle_pct) begin
            byte_if.valid     <= 1'b0;
            byte_if.data_byte <= 8'($urandom);
            byte_if.last_byte <= 1'($urandom);
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= lst;
        do @(posedge i_clk); while (!byte_if.ready);
        n_sent++;
    endtask

    always @(posedge i_clk) begin
        sink_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: event_res %0d symbol %0h",
                       res_if.event_res, res_if.symbol);
                n_errors++;
            end else begin
                want_res = expected_q.pop_front();
                if (res_if.event_res !== want_res.event_res) begin
                    $error("event_res: expected %0d, actual %0d",
                           want_res.event_res, res_if.event_res);
                    n_errors++;
                end
                if (res_if.symbol !== want_res.symbol) begin
                    $error("symbol: expected %0h, actual %0h",
                           want_res.symbol, res_if.symbol);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        int unsigned j;
        int unsigned nb;
        int unsigned kind;
        int unsigned n_ent;
        bit          abort_run;
        logic [7:0]  g;
        logic [7:0]  b;
        t_row        row;

        for (k = 0; k < NODES; k++) begin
            tr_glyph[k] = 8'h00;
            tr_lft[k]   = 0;
            tr_rgt[k]   = 0;
        end
        tr_used   = 1;
        tr_cur    = 0;
        tr_phase  = PS_GLYPH;
        tr_held   = 8'h00;
        tr_halted = 1'b0;

        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= 8'h00;
        byte_if.last_byte <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Some runs open with a broken header; the block halts and must ignore the rest.
        abort_run = ($urandom_range(0, 4) == 0);
        if (abort_run) begin
            kind  = $urandom_range(0, 5);
            n_ent = (kind < 2) ? 0 : $urandom_range(0, 3);
            for (k = 0; k < n_ent; k++) begin
                send_byte(8'($urandom_range(1, 255)), 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                send_byte(CH_COLON, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                nb = $urandom_range(1, 6);
                for (j = 0; j < nb; j++)
                    send_byte($urandom_range(0, 1) ? CH_ONE : CH_ZERO, 1'b0, CHK_MODEL,
                              EV_SYMBOL, 8'h00);
                send_byte(($urandom_range(0, 3) == 0) ? non_bit_byte() : CH_SEP, 1'b0,
                          CHK_MODEL, EV_SYMBOL, 8'h00);
            end
            do g = 8'($urandom_range(1, 255)); while (g == CH_X);
            case (kind)
                0: begin
                    send_byte(CH_X, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                    send_byte(CH_X, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                end
                1: send_byte(8'h00, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                2: begin
                    send_byte(g, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                    do b = 8'($urandom); while (b == CH_COLON);
                    send_byte(b, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                end
                3: begin
                    send_byte(g, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                    send_byte(CH_COLON, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                    send_byte(non_bit_byte(), 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                end
                4: send_byte(8'($urandom), 1'b1, CHK_MODEL, EV_SYMBOL, 8'h00);
                default: begin
                    // grow one code until the node store runs out
                    send_byte(g, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                    send_byte(CH_COLON, 1'b0, CHK_MODEL, EV_SYMBOL, 8'h00);
                    while (!tr_halted)
                        send_byte($urandom_range(0, 1) ? CH_ONE : CH_ZERO, 1'b0, CHK_MODEL,
                                  EV_SYMBOL, 8'h00);
                end
            endcase
        end

        for (k = 0; k < N_DIR; k++) begin
            row = DIR_ROWS[k];
            send_byte(row.b, row.lst, abort_run ? CHK_MODEL : row.chk, row.ev, row.sym);
        end

        if (!tr_halted) begin
            for (k = 0; k < N_DECODE; k++)
                send_byte(path_bit(), ($urandom_range(0, 29) == 0), CHK_MODEL,
                          EV_SYMBOL, 8'h00);
            // end the stream on a fatal data error
            if ($urandom_range(0, 1)) begin
                send_byte(non_bit_byte(), 1'($urandom), CHK_MODEL, EV_SYMBOL, 8'h00);
            end else begin
                while (!tr_halted) begin
                    if (tr_lft[tr_cur] == 0) b = CH_ZERO;
                    else if (tr_rgt[tr_cur] == 0) b = CH_ONE;
                    else b = path_bit();
                    send_byte(b, 1'($urandom), CHK_MODEL, EV_SYMBOL, 8'h00);
                end
            end
        end

        // halted: all of this must be dropped
        nb = abort_run ? N_DECODE : 40;
        for (k = 0; k < nb; k++)
            send_byte(8'($urandom), 1'($urandom), CHK_MODEL, EV_SYMBOL, 8'h00);

        byte_if.valid <= 1'b0;
        snk_stall_pct = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
